@@ rtl/core/fwcrc_pkg.sv @@
// shared types, constants and crc helpers for the firmware image crc verifier
package fwcrc_pkg;

  localparam int BLOCK_BYTES  = 2048;
  localparam int HEADER_BYTES = 32;
  localparam int MAX_BLOCKS   = 256;

  localparam int BLK_WORDS = BLOCK_BYTES / 4;
  localparam int HDR_WORDS = HEADER_BYTES / 4;
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int HDR_SPAN  = HDR_WORDS + MAX_BLOCKS;
  localparam int CNT_W     = $clog2((BLK_WORDS > HDR_SPAN) ? BLK_WORDS : HDR_SPAN) + 1;
  localparam int BT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int TBL_AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LEN_W     = BLK_SHIFT + 1;
  localparam int FLEN_W    = 20;
  localparam int IDX_W     = 8;

  localparam logic [31:0] CRC_POLY      = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] RUN_ADDR_RST  = 32'h0800_0000;
  localparam logic [FLEN_W-1:0] MAX_FILE_RST = FLEN_W'(454656);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BLOCKS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [3:0] {
    ST_HDR_OK     = 4'd0,
    ST_BAD_ADDR   = 4'd1,
    ST_TOO_LONG   = 4'd2,
    ST_MISALIGNED = 4'd3,
    ST_BAD_HLEN   = 4'd4,
    ST_HDR_CRC    = 4'd5,
    ST_BLK_OK     = 4'd6,
    ST_BLK_CRC    = 4'd7,
    ST_IMAGE_OK   = 4'd8
  } status_t;

  typedef enum logic [0:0] {
    REG_RUN_ADDRESS    = 1'b0,
    REG_MAX_FILE_BYTES = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    KIND_START = 1'b0,
    KIND_DATA  = 1'b1
  } kind_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  block_index;
    logic [31:0]       computed_crc;
    logic [31:0]       expected_crc;
    logic              finished;
  } result_t;

  typedef logic [31:0] crc_mat_t [32];

  // column i: contribution of bit i of (crc ^ data) after 32 serial shifts
  function automatic crc_mat_t crc_matrix();
    crc_mat_t m;
    logic [31:0] c;
    for (int i = 0; i < 32; i++) begin
      c = 32'h1 << i;
      for (int j = 0; j < 32; j++) begin
        c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      m[i] = c;
    end
    return m;
  endfunction

  localparam crc_mat_t CRC_MAT = crc_matrix();

  // one whole-word crc step as a xor matrix
  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] data);
    logic [31:0] x;
    logic [31:0] r;
    x = crc ^ data;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      r = r ^ (x[i] ? CRC_MAT[i] : 32'h0);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/fwcrc_ram.sv @@
// generic single-write, single-read ram with registered read data
module fwcrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/firmware_image_crc_verifier_unit.sv @@
// top level of the firmware image crc verifier: header checks, block crc checks
// a result goes into the output register, or the skid stage if the output is stalled;
// start transactions and most data words give no result
// throughput: one transaction per cycle while the skid stage is empty; the word crc
// matrix is combinational, the table ram has one write port, one registered read port
// reset: synchronous; phase goes idle, config registers take their reset values,
// the crc table ram is not cleared (entries are written by the header before use)
module firmware_image_crc_verifier_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [31:0]                  data_word,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [31:0]                  cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [3:0]                   status,
  output logic [fwcrc_pkg::IDX_W-1:0]  block_index,
  output logic [31:0]                  computed_crc,
  output logic [31:0]                  expected_crc,
  output logic                         finished
);

  // configuration
  logic [31:0]                   run_address;
  logic [fwcrc_pkg::FLEN_W-1:0]  max_file_bytes;

  // image state
  fwcrc_pkg::phase_t             phase, phase_next;
  logic [31:0]                   running_crc, running_crc_next;
  logic [fwcrc_pkg::CNT_W-1:0]   word_counter, word_counter_next;
  logic [31:0]                   header_crc_value;
  logic [31:0]                   header_bytes;
  logic [31:0]                   file_length;
  logic [fwcrc_pkg::FLEN_W-1:0]  file_bytes_left;
  logic [fwcrc_pkg::BT_W-1:0]    block_total;
  logic [fwcrc_pkg::BT_W-1:0]    block_current;

  // output register and skid stage
  fwcrc_pkg::result_t out_q, skid_q, res;
  logic               skid_valid;
  logic               res_valid;
  logic               out_load;

  // table ram
  logic                           tbl_we;
  logic [fwcrc_pkg::TBL_AW-1:0]   tbl_waddr;
  logic [31:0]                    tbl_rdata;

  logic in_fire, start_fire, hdr_go, blk_go;

  assign in_ready   = !skid_valid;
  assign in_fire    = in_valid && in_ready;
  assign start_fire = in_fire && (kind == fwcrc_pkg::KIND_START);
  assign hdr_go     = in_fire && (kind == fwcrc_pkg::KIND_DATA) && (phase == fwcrc_pkg::PH_HEADER);
  assign blk_go     = in_fire && (kind == fwcrc_pkg::KIND_DATA) && (phase == fwcrc_pkg::PH_BLOCKS);

  // header word decode
  logic                          n_is0, n_is1, n_is2, n_is3;
  logic [fwcrc_pkg::CNT_W-1:0]   tbl_k;
  logic                          tbl_hit;
  logic [fwcrc_pkg::FLEN_W:0]    bt_sum;
  logic [fwcrc_pkg::FLEN_W:0]    bt_calc;
  logic [31:0]                   hlen_expect;
  logic                          chk_err;
  fwcrc_pkg::status_t            chk_st;
  logic                          hdr_last;

  assign n_is0 = (word_counter == fwcrc_pkg::CNT_W'(0));
  assign n_is1 = (word_counter == fwcrc_pkg::CNT_W'(1));
  assign n_is2 = (word_counter == fwcrc_pkg::CNT_W'(2));
  assign n_is3 = (word_counter == fwcrc_pkg::CNT_W'(3));
  assign tbl_k = word_counter - fwcrc_pkg::CNT_W'(fwcrc_pkg::HDR_WORDS);
  assign tbl_hit = (word_counter >= fwcrc_pkg::CNT_W'(fwcrc_pkg::HDR_WORDS)) &&
                   (tbl_k < fwcrc_pkg::CNT_W'(fwcrc_pkg::MAX_BLOCKS));

  assign bt_sum  = (fwcrc_pkg::FLEN_W+1)'(file_length[fwcrc_pkg::FLEN_W-1:0]) +
                   (fwcrc_pkg::FLEN_W+1)'(fwcrc_pkg::BLOCK_BYTES - 1);
  assign bt_calc = bt_sum >> fwcrc_pkg::BLK_SHIFT;
  assign hlen_expect = 32'(fwcrc_pkg::HEADER_BYTES) + 32'({bt_calc, 2'b00});

  always_comb begin
    chk_err = 1'b1;
    chk_st  = fwcrc_pkg::ST_HDR_OK;
    if (data_word != run_address) begin
      chk_st = fwcrc_pkg::ST_BAD_ADDR;
    end else if (file_length > 32'(max_file_bytes)) begin
      chk_st = fwcrc_pkg::ST_TOO_LONG;
    end else if (bt_calc > (fwcrc_pkg::FLEN_W+1)'(fwcrc_pkg::MAX_BLOCKS)) begin
      chk_st = fwcrc_pkg::ST_TOO_LONG;
    end else if (data_word[fwcrc_pkg::BLK_SHIFT-1:0] != '0) begin
      chk_st = fwcrc_pkg::ST_MISALIGNED;
    end else if (header_bytes != hlen_expect) begin
      chk_st = fwcrc_pkg::ST_BAD_HLEN;
    end else begin
      chk_err = 1'b0;
    end
  end

  assign hdr_last = (word_counter >= fwcrc_pkg::CNT_W'(3)) &&
                    ((fwcrc_pkg::CNT_W+1)'(word_counter) ==
                     (fwcrc_pkg::CNT_W+1)'(fwcrc_pkg::HDR_WORDS - 1) +
                     (fwcrc_pkg::CNT_W+1)'(block_total));

  // block word masking: keep only bytes below the remaining file length
  logic [fwcrc_pkg::LEN_W-1:0] blk_len;
  logic [fwcrc_pkg::LEN_W-1:0] blk_off;
  logic [31:0]                 blk_word;

  assign blk_len = (file_bytes_left < fwcrc_pkg::FLEN_W'(fwcrc_pkg::BLOCK_BYTES)) ?
                   fwcrc_pkg::LEN_W'(file_bytes_left) :
                   fwcrc_pkg::LEN_W'(fwcrc_pkg::BLOCK_BYTES);
  assign blk_off = {word_counter[fwcrc_pkg::LEN_W-3:0], 2'b00};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      blk_word[8*k +: 8] = (((fwcrc_pkg::LEN_W+1)'(blk_off) + (fwcrc_pkg::LEN_W+1)'(k)) <
                            (fwcrc_pkg::LEN_W+1)'(blk_len)) ? data_word[8*k +: 8] : 8'h00;
    end
  end

  logic [31:0]                 crc_upd;
  logic                        blk_end;
  logic                        blk_last;
  logic [fwcrc_pkg::BT_W:0]    blk_cur_inc;

  assign crc_upd     = fwcrc_pkg::crc_word(running_crc,
                                           (phase == fwcrc_pkg::PH_BLOCKS) ? blk_word : data_word);
  assign blk_end     = (word_counter == fwcrc_pkg::CNT_W'(fwcrc_pkg::BLK_WORDS - 1));
  assign blk_cur_inc = (fwcrc_pkg::BT_W+1)'(block_current) + (fwcrc_pkg::BT_W+1)'(1);
  assign blk_last    = blk_cur_inc >= (fwcrc_pkg::BT_W+1)'(block_total);

  // next phase
  always_comb begin
    phase_next = phase;
    if (start_fire) begin
      phase_next = fwcrc_pkg::PH_HEADER;
    end else if (hdr_go && n_is3 && chk_err) begin
      phase_next = fwcrc_pkg::PH_ERROR;
    end else if (hdr_go && !n_is0 && hdr_last) begin
      if (crc_upd != header_crc_value) begin
        phase_next = fwcrc_pkg::PH_ERROR;
      end else if (block_total == '0) begin
        phase_next = fwcrc_pkg::PH_DONE;
      end else begin
        phase_next = fwcrc_pkg::PH_BLOCKS;
      end
    end else if (blk_go && blk_end) begin
      if (crc_upd != tbl_rdata) begin
        phase_next = fwcrc_pkg::PH_ERROR;
      end else if (blk_last) begin
        phase_next = fwcrc_pkg::PH_DONE;
      end
    end
  end

  // result and datapath next values
  always_comb begin
    res_valid         = 1'b0;
    res               = '0;
    running_crc_next  = running_crc;
    word_counter_next = word_counter;
    if (start_fire) begin
      running_crc_next  = fwcrc_pkg::CRC_INIT;
      word_counter_next = '0;
    end else if (hdr_go) begin
      word_counter_next = word_counter + fwcrc_pkg::CNT_W'(1);
      if (!n_is0) begin
        running_crc_next = crc_upd;
      end
      if (n_is3 && chk_err) begin
        res_valid    = 1'b1;
        res.status   = chk_st;
        res.finished = 1'b1;
      end else if (!n_is0 && hdr_last) begin
        running_crc_next  = fwcrc_pkg::CRC_INIT;
        word_counter_next = '0;
        res_valid         = 1'b1;
        res.computed_crc  = crc_upd;
        res.expected_crc  = header_crc_value;
        if (crc_upd != header_crc_value) begin
          res.status   = fwcrc_pkg::ST_HDR_CRC;
          res.finished = 1'b1;
        end else if (block_total == '0) begin
          res.status   = fwcrc_pkg::ST_IMAGE_OK;
          res.finished = 1'b1;
        end else begin
          res.status   = fwcrc_pkg::ST_HDR_OK;
        end
      end
    end else if (blk_go) begin
      running_crc_next  = crc_upd;
      word_counter_next = word_counter + fwcrc_pkg::CNT_W'(1);
      if (blk_end) begin
        running_crc_next  = fwcrc_pkg::CRC_INIT;
        word_counter_next = '0;
        res_valid         = 1'b1;
        res.block_index   = fwcrc_pkg::IDX_W'(block_current);
        res.computed_crc  = crc_upd;
        res.expected_crc  = tbl_rdata;
        if (crc_upd != tbl_rdata) begin
          res.status   = fwcrc_pkg::ST_BLK_CRC;
          res.finished = 1'b1;
        end else if (blk_last) begin
          res.status   = fwcrc_pkg::ST_IMAGE_OK;
          res.finished = 1'b1;
        end else begin
          res.status   = fwcrc_pkg::ST_BLK_OK;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= fwcrc_pkg::PH_IDLE;
      running_crc  <= fwcrc_pkg::CRC_INIT;
      word_counter <= '0;
      run_address  <= fwcrc_pkg::RUN_ADDR_RST;
      max_file_bytes <= fwcrc_pkg::MAX_FILE_RST;
      header_crc_value <= '0;
      header_bytes     <= '0;
      file_length      <= '0;
      file_bytes_left  <= '0;
      block_total      <= '0;
      block_current    <= '0;
    end else begin
      phase        <= phase_next;
      running_crc  <= running_crc_next;
      word_counter <= word_counter_next;
      if (cfg_write) begin
        unique case (fwcrc_pkg::reg_idx_t'(cfg_index))
          fwcrc_pkg::REG_RUN_ADDRESS:    run_address    <= cfg_data;
          fwcrc_pkg::REG_MAX_FILE_BYTES: max_file_bytes <= cfg_data[fwcrc_pkg::FLEN_W-1:0];
        endcase
      end
      if (start_fire) begin
        header_crc_value <= '0;
        header_bytes     <= '0;
        file_length      <= '0;
        file_bytes_left  <= '0;
        block_total      <= '0;
        block_current    <= '0;
      end else if (hdr_go) begin
        if (n_is0) begin
          header_crc_value <= data_word;
        end
        if (n_is1) begin
          header_bytes <= data_word;
        end
        if (n_is2) begin
          file_length <= data_word;
        end
        if (n_is3 && !chk_err) begin
          block_total     <= fwcrc_pkg::BT_W'(bt_calc);
          file_bytes_left <= file_length[fwcrc_pkg::FLEN_W-1:0];
        end
      end else if (blk_go && blk_end) begin
        file_bytes_left <= file_bytes_left - fwcrc_pkg::FLEN_W'(blk_len);
        block_current   <= fwcrc_pkg::BT_W'(blk_cur_inc);
      end
    end
  end

  // stored block crcs go to the ram; the read port follows the current block
  assign tbl_we    = hdr_go && tbl_hit;
  assign tbl_waddr = fwcrc_pkg::TBL_AW'(tbl_k);

  fwcrc_ram #(
    .WIDTH(32),
    .DEPTH(fwcrc_pkg::MAX_BLOCKS)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (data_word),
    .raddr (fwcrc_pkg::TBL_AW'(block_current)),
    .rdata (tbl_rdata)
  );

  // output register with skid stage behind it
  assign out_load = out_ready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign status       = out_q.status;
  assign block_index  = out_q.block_index;
  assign computed_crc = out_q.computed_crc;
  assign expected_crc = out_q.expected_crc;
  assign finished     = out_q.finished;

  // a held result in the skid stage always has one in front of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a transaction with output register empty");

  // results only come from data words in the header or block phase
  a_res_source: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (hdr_go || blk_go))
    else $error("result produced outside header or block phase");

  // a finishing result always leaves the block in done or error
  a_finish_phase: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.finished) |=>
      (phase == fwcrc_pkg::PH_DONE || phase == fwcrc_pkg::PH_ERROR))
    else $error("finished result did not end the image check");

  // block streaming never runs past the block count
  a_block_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == fwcrc_pkg::PH_BLOCKS) |->
      (block_current < block_total &&
       word_counter < fwcrc_pkg::CNT_W'(fwcrc_pkg::BLK_WORDS)))
    else $error("block counters out of range");

endmodule

@@ test/fwcrc_tb_pkg.sv @@
// crc and tail-masking helpers shared by the image stimulus and the verdict checker
package fwcrc_tb_pkg;

  // serial msb-first crc-32 over one whole word
  function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc ^ w;
    repeat (32) c = c[31] ? ((c << 1) ^ fwcrc_pkg::CRC_POLY) : (c << 1);
    return c;
  endfunction

  // zero the bytes of a word that lie past the end of the file
  function automatic logic [31:0] pad_mask(input logic [31:0] w, input int unsigned off,
                                           input int unsigned len);
    if (off >= len) return 32'h0;
    if (off + 4 > len) return w & ((32'h1 << (8 * (len - off))) - 32'h1);
    return w;
  endfunction

endpackage

@@ test/image_verdict_checker.sv @@
// verdict predictor and checker for the firmware image crc verifier
module image_verdict_checker
  import fwcrc_pkg::*;
  import fwcrc_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              kind,
  input  logic [31:0]       data_word,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [3:0]        status,
  input  logic [IDX_W-1:0]  block_index,
  input  logic [31:0]       computed_crc,
  input  logic [31:0]       expected_crc,
  input  logic              finished,
  output int                mismatch_count,
  output int                verdicts_owed
);

  logic [31:0]       run_addr_cfg;
  logic [FLEN_W-1:0] max_len_cfg;

  phase_t      img_phase;
  logic [31:0] img_crc;
  logic [31:0] hdr_crc_word;
  logic [31:0] hdr_len_word;
  logic [31:0] flen_word;
  int unsigned bytes_left;
  int unsigned blk_total;
  int unsigned blk_cur;
  int unsigned word_no;
  logic [31:0] crc_table [MAX_BLOCKS];

  result_t verdict_q[$];

  task automatic push_verdict(input status_t st, input int unsigned idx, input logic [31:0] comp,
                              input logic [31:0] stored, input logic fin);
    result_t r;
    r.status       = st;
    r.block_index  = IDX_W'(idx);
    r.computed_crc = comp;
    r.expected_crc = stored;
    r.finished     = fin;
    verdict_q.push_back(r);
  endtask

  task automatic compare_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t     want;
    logic [31:0] w;
    logic [31:0] comp;
    int unsigned n;
    int unsigned len;
    int unsigned idx;
    status_t     st;
    if (rst) begin
      run_addr_cfg = RUN_ADDR_RST;
      max_len_cfg = MAX_FILE_RST;
      img_phase = PH_IDLE;
      verdict_q.delete();
      mismatch_count = 0;
      verdicts_owed <= 0;
    end else begin
      if (cfg_write) begin
        if (reg_idx_t'(cfg_index) == REG_RUN_ADDRESS) run_addr_cfg = cfg_data;
        else max_len_cfg = cfg_data[FLEN_W-1:0];
      end

      if (in_valid && in_ready) begin
        w = data_word;
        if (kind_t'(kind) == KIND_START) begin
          img_crc = CRC_INIT;
          word_no = 0;
          hdr_crc_word = 32'h0;
          hdr_len_word = 32'h0;
          flen_word = 32'h0;
          bytes_left = 0;
          blk_total = 0;
          blk_cur = 0;
          img_phase = PH_HEADER;
        end else if (img_phase == PH_HEADER) begin
          n = word_no;
          word_no = n + 1;
          if (n == 0) begin
            hdr_crc_word = w;
          end else begin
            img_crc = crc32_word(img_crc, w);
            st = ST_HDR_OK;
            case (n)
              1: hdr_len_word = w;
              2: flen_word = w;
              3: begin
                // checks run in a fixed order, first failure wins
                if (w != run_addr_cfg) begin
                  st = ST_BAD_ADDR;
                end else if (flen_word > max_len_cfg) begin
                  st = ST_TOO_LONG;
                end else begin
                  blk_total = (flen_word + BLOCK_BYTES - 1) / BLOCK_BYTES;
                  if (blk_total > MAX_BLOCKS) st = ST_TOO_LONG;
                  else if (w[BLK_SHIFT-1:0] != '0) st = ST_MISALIGNED;
                  else if (hdr_len_word != HEADER_BYTES + 4 * blk_total) st = ST_BAD_HLEN;
                end
                if (st != ST_HDR_OK) begin
                  img_phase = PH_ERROR;
                  push_verdict(st, 0, 32'h0, 32'h0, 1'b1);
                end else begin
                  bytes_left = flen_word;
                end
              end
              default: begin
                if (n >= HDR_WORDS && n - HDR_WORDS < MAX_BLOCKS) crc_table[n - HDR_WORDS] = w;
              end
            endcase
            if (img_phase == PH_HEADER && n >= 3 && n == HDR_WORDS - 1 + blk_total) begin
              comp = img_crc;
              img_crc = CRC_INIT;
              word_no = 0;
              if (comp != hdr_crc_word) begin
                img_phase = PH_ERROR;
                push_verdict(ST_HDR_CRC, 0, comp, hdr_crc_word, 1'b1);
              end else if (blk_total == 0) begin
                img_phase = PH_DONE;
                push_verdict(ST_IMAGE_OK, 0, comp, hdr_crc_word, 1'b1);
              end else begin
                img_phase = PH_BLOCKS;
                push_verdict(ST_HDR_OK, 0, comp, hdr_crc_word, 1'b0);
              end
            end
          end
        end else if (img_phase == PH_BLOCKS) begin
          len = (bytes_left < BLOCK_BYTES) ? bytes_left : BLOCK_BYTES;
          img_crc = crc32_word(img_crc, pad_mask(w, 4 * word_no, len));
          word_no++;
          if (word_no == BLK_WORDS) begin
            comp = img_crc;
            img_crc = CRC_INIT;
            word_no = 0;
            bytes_left -= len;
            idx = blk_cur;
            blk_cur = idx + 1;
            if (comp != crc_table[idx]) begin
              img_phase = PH_ERROR;
              push_verdict(ST_BLK_CRC, idx, comp, crc_table[idx], 1'b1);
            end else if (blk_cur >= blk_total) begin
              img_phase = PH_DONE;
              push_verdict(ST_IMAGE_OK, idx, comp, crc_table[idx], 1'b1);
            end else begin
              push_verdict(ST_BLK_OK, idx, comp, crc_table[idx], 1'b0);
            end
          end
        end
      end

      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: no verdict expected, actual status %0d block %0d crc %h/%h", $time,
                   status, block_index, computed_crc, expected_crc);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          compare_field("status", 32'(want.status), 32'(status));
          compare_field("block_index", 32'(want.block_index), 32'(block_index));
          compare_field("computed_crc", want.computed_crc, computed_crc);
          compare_field("expected_crc", want.expected_crc, expected_crc);
          compare_field("finished", 32'(want.finished), 32'(finished));
        end
      end
      verdicts_owed <= verdict_q.size();
    end
  end

endmodule

@@ test/tb.sv @@
// testbench top: clock, reset, image stimulus and final verdict for the crc verifier
module tb;
  import fwcrc_pkg::*;
  import fwcrc_tb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {FLAW_NONE, FLAW_HDR_CRC, FLAW_BLK_DATA, FLAW_BLK_TABLE} flaw_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic kind = 1'b0;
  logic [31:0] data_word = 32'h0;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = 32'h0;
  logic out_ready = 1'b0;

  logic in_ready;
  logic out_valid;
  logic [3:0] status;
  logic [IDX_W-1:0] block_index;
  logic [31:0] computed_crc;
  logic [31:0] expected_crc;
  logic finished;

  int mismatch_count;
  int verdicts_owed;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  logic [31:0] cur_run = RUN_ADDR_RST;
  int unsigned cur_max = MAX_FILE_RST;

  firmware_image_crc_verifier_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .data_word(data_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .block_index(block_index),
    .computed_crc(computed_crc), .expected_crc(expected_crc), .finished(finished)
  );

  image_verdict_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .data_word(data_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .block_index(block_index),
    .computed_crc(computed_crc), .expected_crc(expected_crc), .finished(finished),
    .mismatch_count(mismatch_count), .verdicts_owed(verdicts_owed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog: give up when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input kind_t k, input logic [31:0] w);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    data_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering and wait until every verdict is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] run, input int unsigned max_len);
    cfg_write <= 1'b1;
    cfg_index <= REG_RUN_ADDRESS;
    cfg_data <= run;
    @(posedge clk);
    cfg_index <= REG_MAX_FILE_BYTES;
    cfg_data <= 32'(max_len);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_run = run;
    cur_max = max_len;
  endtask

  // builds a header with a block crc table and block data; cut < 0 sends everything
  task automatic send_image(input logic [31:0] addr, input logic [31:0] flen, input int hlen_skew,
                            input flaw_t flaw, input int cut, input bit with_body);
    logic [31:0] hdr[$];
    logic [31:0] body[$];
    logic [31:0] crc;
    logic [31:0] w;
    longint need;
    int ntbl;
    int nblk;
    int len;
    need = (longint'(flen) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    ntbl = (need <= MAX_BLOCKS) ? int'(need) : 0;
    nblk = (need <= 4) ? int'(need) : 0;
    hdr.push_back(32'h0);
    hdr.push_back(32'(HEADER_BYTES + 4 * ntbl + hlen_skew));
    hdr.push_back(flen);
    hdr.push_back(addr);
    repeat (4) hdr.push_back($urandom);
    for (int b = 0; b < ntbl; b++) begin
      if (b < nblk) begin
        len = int'(flen) - b * BLOCK_BYTES;
        if (len > BLOCK_BYTES) len = BLOCK_BYTES;
        crc = CRC_INIT;
        for (int i = 0; i < BLK_WORDS; i++) begin
          w = $urandom;
          body.push_back(w);
          crc = crc32_word(crc, pad_mask(w, 4 * i, len));
        end
        hdr.push_back(crc);
      end else begin
        hdr.push_back($urandom);
      end
    end
    if (flaw == FLAW_BLK_TABLE && nblk > 0)
      hdr[HDR_WORDS + $urandom_range(0, nblk - 1)] ^= 32'h1 << $urandom_range(0, 31);
    if (flaw == FLAW_BLK_DATA && nblk > 0)
      body[$urandom_range(0, body.size() - 1)] ^= 32'h1 << $urandom_range(0, 31);
    crc = CRC_INIT;
    for (int i = 1; i < hdr.size(); i++) crc = crc32_word(crc, hdr[i]);
    hdr[0] = (flaw == FLAW_HDR_CRC) ? crc ^ (32'h1 << $urandom_range(0, 31)) : crc;
    if (with_body) hdr = {hdr, body};
    send_item(KIND_START, $urandom);
    for (int i = 0; i < hdr.size() && (cut < 0 || i < cut); i++) send_item(KIND_DATA, hdr[i]);
    // stray words follow; the block ignores them once the image check is done or has failed
    repeat ($urandom_range(0, 2)) send_item(KIND_DATA, $urandom);
  endtask

  task automatic random_image();
    int pick;
    int nb;
    int skew;
    int unsigned lim;
    logic [31:0] flen;
    logic [31:0] addr;
    flaw_t fl;
    pick = $urandom_range(0, 99);
    lim = (cur_max < 8192) ? cur_max : 8192;
    if (pick < 5) begin
      nb = $urandom_range(0, 19);
      nb = (nb < 14) ? 1 : (nb < 19) ? 2 : 3;
      flen = (nb - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES);
      if (flen > cur_max) flen = cur_max;
      nb = $urandom_range(0, 9);
      fl = (nb < 7) ? FLAW_NONE : (nb < 8) ? FLAW_BLK_DATA : FLAW_BLK_TABLE;
      send_image(cur_run, flen, 0, fl, -1, 1'b1);
    end else if (pick < 26) begin
      send_image(cur_run, 32'h0, 0, (pick < 23) ? FLAW_NONE : FLAW_HDR_CRC, -1, 1'b0);
    end else if (pick < 40) begin
      addr = ($urandom_range(0, 1) == 0) ? cur_run ^ (32'h1 << $urandom_range(0, 31)) : $urandom;
      if (addr == cur_run) addr = ~cur_run;
      send_image(addr, $urandom_range(0, lim), 0, FLAW_NONE, $urandom_range(4, 10), 1'b0);
    end else if (pick < 52) begin
      flen = ($urandom_range(0, 1) == 0) ? cur_max + 1 + $urandom_range(0, 3000) : $urandom;
      if (flen <= cur_max) flen = cur_max + 1;
      send_image(cur_run, flen, 0, FLAW_NONE, $urandom_range(4, 10), 1'b0);
    end else if (pick < 64) begin
      skew = (($urandom_range(0, 1) == 0) ? 4 : -4) * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) skew = $urandom_range(1, 3);
      send_image(cur_run, $urandom_range(0, lim), skew, FLAW_NONE, $urandom_range(4, 10), 1'b0);
    end else if (pick < 80) begin
      send_image(cur_run, $urandom_range(0, lim), 0, FLAW_HDR_CRC, -1, 1'b0);
    end else if (pick < 90) begin
      // broken sequence: the next start cuts it short
      send_image(cur_run, $urandom_range(0, lim), 0, FLAW_NONE, $urandom_range(0, 40), 1'b1);
    end else begin
      repeat ($urandom_range(1, 6)) send_item(kind_t'($urandom_range(0, 1)), $urandom);
    end
  endtask

  task automatic run_phase(input logic [31:0] run, input int unsigned max_len, input int budget);
    int stop_at;
    drain();
    set_config(run, max_len);
    stop_at = items_sent + budget;
    while (items_sent < stop_at) random_image();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // data words before any start are dropped
    send_item(KIND_DATA, 32'hFFFF_FFFF);
    send_item(KIND_DATA, 32'h0000_0000);
    send_image(cur_run, 32'h0, 0, FLAW_NONE, -1, 1'b1);
    send_image(cur_run, BLOCK_BYTES + 6, 0, FLAW_NONE, -1, 1'b1);
    send_image(cur_run, 32'h1, 0, FLAW_BLK_TABLE, -1, 1'b1);
    send_image(cur_run ^ 32'h8000_0000, 100, 0, FLAW_NONE, -1, 1'b0);
    send_image(cur_run, cur_max + 1, 0, FLAW_NONE, 6, 1'b0);
    send_image(cur_run, 4096, 4, FLAW_NONE, -1, 1'b0);
    send_image(cur_run, 4096, -4, FLAW_NONE, -1, 1'b0);
    send_image(cur_run, 5 * BLOCK_BYTES, 0, FLAW_HDR_CRC, -1, 1'b0);
    send_image(cur_run, 100, 0, FLAW_NONE, 5, 1'b0);

    // long hold on the result side while error headers keep coming
    hold_req = 1'b1;
    repeat (12) send_image(~cur_run, 100, 0, FLAW_NONE, 5, 1'b0);

    drain();
    set_config(32'h0000_0000, 524288);
    send_image(cur_run, 524288, 0, FLAW_HDR_CRC, -1, 1'b0);
    send_image(cur_run, 524289, 0, FLAW_NONE, -1, 1'b0);
    send_image(cur_run, 524288, 0, FLAW_NONE, 20, 1'b0);
    send_image(cur_run, 32'hFFFF_FFFF, 0, FLAW_NONE, 8, 1'b0);

    drain();
    set_config(32'h0800_0004, 2048);
    send_image(cur_run, 100, 0, FLAW_NONE, -1, 1'b0);

    run_phase(32'h0000_0000, 524288, 30);
    run_phase($urandom & ~32'(BLOCK_BYTES - 1), $urandom_range(2048, 524288), 30);
    run_phase(32'hFFFF_F800, 0, 15);
    run_phase(32'hFFFF_FFFF, $urandom_range(0, 524288), 15);
    idle_on = 1'b0;
    run_phase(RUN_ADDR_RST, 524288, 60);

    drain();
    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
